FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during rst
`define AZR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("azr: assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define AZR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("azr: assertion failed");

`else

`define AZR_ASSERT_IMP(label, ante, cons)
`define AZR_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: hdl/azr_pkg.sv
// ---------------------------------------------------------------------------
// azr_pkg
// Types, widths and arctangent table for the azimuth/elevation/range block.
// ---------------------------------------------------------------------------
package azr_pkg;

  localparam int COORD_W  = 48;
  localparam int ANGLE_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int LO_W     = (COORD_W + 1) / 2;
  localparam int HI_W     = COORD_W - LO_W;
  localparam int SQ_W     = 2 * COORD_W + 2;
  localparam int T_W      = SQ_W + 1;
  localparam int ROOT_W   = COORD_W + 1;
  localparam int OPW      = COORD_W + 2;
  localparam int NW       = 64;
  localparam int POS_W    = $clog2(OPW);
  localparam int SH_W     = 6;
  localparam int NORM_POS = 59;

  localparam logic [NW-1:0] ACC_ONE   = 64'h4000_0000_0000_0000;
  localparam logic [NW-1:0] HALF_TURN = 64'h2000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FROM_UNDEF = 2'd1,
    ST_TO_UNDEF   = 2'd2,
    ST_FRAME      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] from_z;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic signed [COORD_W-1:0] to_z;
    logic [7:0]                from_frame;
    logic [7:0]                to_frame;
    logic                      from_defined;
    logic                      to_defined;
    logic                      z_negative;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [ANGLE_W-1:0]        azimuth;
    logic signed [ANGLE_W-1:0] elevation;
    logic [COORD_W:0]          range;
  } res_t;

  // Front pipeline tag: status and difference vector
  typedef struct packed {
    status_t                  status;
    logic                     blank;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } meta_t;

  typedef struct packed {
    logic [2*LO_W-1:0]      ll;
    logic [HI_W+LO_W-1:0]   hl;
    logic [2*HI_W-1:0]      hh;
  } prod_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  typedef struct packed {
    meta_t meta;
    root_t hor;
    root_t full;
  } sqrt_t;

  // Back pipeline tag
  typedef struct packed {
    status_t           status;
    logic              blank;
    logic [ROOT_W-1:0] rng;
  } tail_t;

  typedef struct packed {
    logic signed [OPW-1:0] x;
    logic signed [OPW-1:0] y;
    logic [OPW-1:0]        m;
    logic                  half;
  } oper_t;

  typedef struct packed {
    logic signed [OPW-1:0] x;
    logic signed [OPW-1:0] y;
    logic                  right;
    logic [SH_W-1:0]       amt;
    logic                  half;
  } shift_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] ang;
    logic                 hold;
    logic                 half;
  } vec_t;

  typedef struct packed {
    tail_t tail;
    vec_t  az;
    vec_t  el;
  } cordic_t;

  // Bitwise restoring divide, elaboration use only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) at 2^62 scale by truncated Taylor series
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] d;
    logic        fin;
    int it;
    t   = udiv(ACC_ONE, n);
    s   = t;
    k   = 64'd1;
    fin = 1'b0;
    for (it = 0; it < 64; it++) begin
      if (!fin) begin
        t = udiv(udiv(t, n), n);
        if (t == '0) begin
          fin = 1'b1;
        end else begin
          d = udiv(t, (k << 1) + 64'd1);
          if (k[0]) s = s - d;
          else s = s + d;
          k = k + 64'd1;
        end
      end
    end
    return s;
  endfunction

  // atan(2^-i) in turns, 2^62 per turn, truncated
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] quo;
    logic [63:0] rem;
    int b;
    q = (atan_inv(64'd5) << 2) - atan_inv(64'd239);
    r = (i == 0) ? q : atan_inv(64'd1 << i);
    if (r >= q) begin
      quo = 64'd1;
      rem = r - q;
    end else begin
      quo = '0;
      rem = r;
    end
    for (b = 0; b < 59; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= q) begin
        rem    = rem - q;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Position of the highest set bit
  function automatic logic [POS_W-1:0] msb_pos(input logic [OPW-1:0] m);
    logic [POS_W-1:0] p;
    int b;
    p = '0;
    for (b = 0; b < OPW; b++) begin
      if (m[b]) p = POS_W'(b);
    end
    return p;
  endfunction

  // One vectoring micro-rotation toward y = 0
  function automatic vec_t cordic_rot(input vec_t v, input int step,
                                      input logic [NW-1:0] tab);
    vec_t r;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] sy;
    r  = v;
    sx = v.y >>> step;
    sy = v.x >>> step;
    if (!v.y[NW-1]) begin
      r.x   = v.x + sx;
      r.y   = v.y - sy;
      r.ang = v.ang + $signed(tab);
    end else begin
      r.x   = v.x - sx;
      r.y   = v.y + sy;
      r.ang = v.ang - $signed(tab);
    end
    return r;
  endfunction

endpackage

FILE: hdl/azr_sqrt_cell.sv
// ---------------------------------------------------------------------------
// azr_sqrt_cell
// One result bit of two digit-by-digit square roots, registered.
// ---------------------------------------------------------------------------
module azr_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  azr_pkg::sqrt_t up,
  output logic          down_valid,
  output azr_pkg::sqrt_t down
);
  import azr_pkg::*;

  // Try setting root bit BIT: keep it if (q + 2^BIT)^2 fits
  function automatic root_t sq_step(input root_t v);
    root_t r;
    logic [T_W-1:0] t;
    r = v;
    t = (T_W'(v.root) << (BIT + 1)) + (T_W'(1) << (2 * BIT));
    if ({1'b0, v.rem} >= t) begin
      r.rem       = v.rem - t[SQ_W-1:0];
      r.root[BIT] = 1'b1;
    end
    return r;
  endfunction

  sqrt_t down_next;

  // Step both roots
  always_comb begin
    down_next      = up;
    down_next.hor  = sq_step(up.hor);
    down_next.full = sq_step(up.full);
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else begin
      down_valid <= up_valid;
    end
  end

  // Advance word
  always_ff @(posedge clk) begin
    down <= down_next;
  end

endmodule

FILE: hdl/azr_cordic_cell.sv
// ---------------------------------------------------------------------------
// azr_cordic_cell
// One CORDIC vectoring iteration for azimuth and elevation, registered.
// ---------------------------------------------------------------------------
module azr_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  azr_pkg::cordic_t up,
  output logic            down_valid,
  output azr_pkg::cordic_t down
);
  import azr_pkg::*;

  localparam logic [NW-1:0] ATAN = atan_entry(STEP);

  cordic_t down_next;

  // Rotate both vectors
  always_comb begin
    down_next    = up;
    down_next.az = cordic_rot(up.az, STEP, ATAN);
    down_next.el = cordic_rot(up.el, STEP, ATAN);
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else begin
      down_valid <= up_valid;
    end
  end

  // Advance word
  always_ff @(posedge clk) begin
    down <= down_next;
  end

endmodule

FILE: hdl/cartesian_to_azimuth_elevation_range.sv
// Path from accept to done: input stages, square-root row, CORDIC setup, CORDIC row, output.
// Throughput: one word per cycle; busy stays low, the square-root cell row and the
//   CORDIC cell row are fully pipelined, one bit or one iteration per cell.
// Reset: rst clears every stage valid bit; words in flight are dropped.
// done pulses for one cycle per word; the receiver cannot stall the block.
// ---------------------------------------------------------------------------
// cartesian_to_azimuth_elevation_range
// Direction and distance between two positions: square-root and CORDIC rows.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_azimuth_elevation_range #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  azr_pkg::req_t req,
  output logic          done,
  output azr_pkg::res_t res
);
  import azr_pkg::*;

  localparam logic [NW-1:0] RND = NW'(1) << (61 - ANGLE_W);
  localparam logic signed [NW-1:0] EL_LIM = NW'(1) << (ANGLE_W - 2);

  // Widen a coordinate by sign
  function automatic logic signed [DIFF_W-1:0] sx_coord(input logic [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic [COORD_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? -v : v;
    return a[COORD_W-1:0];
  endfunction

  function automatic prod_t square_parts(input logic [COORD_W-1:0] a);
    prod_t p;
    p.ll = (2*LO_W)'(a[LO_W-1:0]) * (2*LO_W)'(a[LO_W-1:0]);
    p.hl = (HI_W+LO_W)'(a[COORD_W-1:LO_W]) * (HI_W+LO_W)'(a[LO_W-1:0]);
    p.hh = (2*HI_W)'(a[COORD_W-1:LO_W]) * (2*HI_W)'(a[COORD_W-1:LO_W]);
    return p;
  endfunction

  function automatic logic [SQ_W-1:0] square_sum(input prod_t p);
    return (SQ_W'(p.hh) << (2 * LO_W)) + (SQ_W'(p.hl) << (LO_W + 1)) + SQ_W'(p.ll);
  endfunction

  function automatic logic [ROOT_W-1:0] round_root(input root_t v);
    return (v.rem > SQ_W'(v.root)) ? v.root + ROOT_W'(1) : v.root;
  endfunction

  function automatic oper_t make_oper(input logic signed [OPW-1:0] x,
                                      input logic signed [OPW-1:0] y,
                                      input logic half);
    oper_t o;
    logic [OPW-1:0] ym;
    o.x    = x;
    o.y    = y;
    o.half = half;
    ym     = y[OPW-1] ? -y : y;
    o.m    = ($unsigned(x) >= ym) ? $unsigned(x) : ym;
    return o;
  endfunction

  function automatic shift_t make_shift(input oper_t o);
    shift_t s;
    logic [POS_W-1:0] p;
    p       = msb_pos(o.m);
    s.x     = o.x;
    s.y     = o.y;
    s.half  = o.half;
    s.right = (int'(p) > NORM_POS);
    s.amt   = s.right ? SH_W'(int'(p) - NORM_POS) : SH_W'(NORM_POS - int'(p));
    return s;
  endfunction

  function automatic vec_t make_vec(input shift_t s);
    vec_t v;
    logic signed [NW-1:0] ex;
    logic signed [NW-1:0] ey;
    ex     = {{(NW-OPW){s.x[OPW-1]}}, s.x};
    ey     = {{(NW-OPW){s.y[OPW-1]}}, s.y};
    v.x    = s.right ? (ex >>> s.amt) : (ex <<< s.amt);
    v.y    = s.right ? (ey >>> s.amt) : (ey <<< s.amt);
    v.half = s.half;
    v.ang  = s.half ? $signed(HALF_TURN) : '0;
    v.hold = (s.y == '0);
    return v;
  endfunction

  function automatic logic signed [NW-1:0] to_angle(input vec_t v);
    logic signed [NW-1:0] acc;
    acc = v.hold ? (v.half ? $signed(HALF_TURN) : '0) : v.ang;
    return (acc + $signed(RND)) >>> (62 - ANGLE_W);
  endfunction

  // ---------------- input stage ----------------
  logic  s0_valid;
  meta_t s0, s0_next;
  logic  s1_valid;
  meta_t s1_meta;
  prod_t s1_px, s1_py, s1_pz;
  logic  s2_valid;
  meta_t s2_meta;
  logic [SQ_W-1:0] s2_sx, s2_sy, s2_sz;

  assign busy = 1'b0;

  // Status, differences and sign of dz
  always_comb begin
    logic signed [DIFF_W-1:0] dz;
    s0_next.dx = sx_coord(req.to_x) - sx_coord(req.from_x);
    s0_next.dy = sx_coord(req.to_y) - sx_coord(req.from_y);
    dz         = sx_coord(req.to_z) - sx_coord(req.from_z);
    s0_next.dz = req.z_negative ? -dz : dz;
    priority if (!req.from_defined) s0_next.status = ST_FROM_UNDEF;
    else if (!req.to_defined)       s0_next.status = ST_TO_UNDEF;
    else if (req.from_frame != req.to_frame) s0_next.status = ST_FRAME;
    else                            s0_next.status = ST_OK;
    s0_next.blank = (s0_next.status != ST_OK) ||
                    (s0_next.dx == '0 && s0_next.dy == '0 && dz == '0);
  end

  // Advance front valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  // Capture, split-multiply, then sum the squares
  always_ff @(posedge clk) begin
    s0      <= s0_next;
    s1_meta <= s0;
    s1_px   <= square_parts(mag_of(s0.dx));
    s1_py   <= square_parts(mag_of(s0.dy));
    s1_pz   <= square_parts(mag_of(s0.dz));
    s2_meta <= s1_meta;
    s2_sx   <= square_sum(s1_px);
    s2_sy   <= square_sum(s1_py);
    s2_sz   <= square_sum(s1_pz);
  end

  // ---------------- square-root cell row ----------------
  logic  sq_valid [0:ROOT_W];
  sqrt_t sq_pipe  [0:ROOT_W];

  // Load sums of squares with empty roots
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_pipe[0].meta      <= s2_meta;
    sq_pipe[0].hor.rem   <= s2_sx + s2_sy;
    sq_pipe[0].hor.root  <= '0;
    sq_pipe[0].full.rem  <= s2_sx + s2_sy + s2_sz;
    sq_pipe[0].full.root <= '0;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    azr_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (sq_valid[j]),
      .up         (sq_pipe[j]),
      .down_valid (sq_valid[j+1]),
      .down       (sq_pipe[j+1])
    );
  end

  // ---------------- CORDIC setup ----------------
  logic   p1_valid, p2_valid;
  tail_t  p1_tail, p2_tail;
  oper_t  p1_az, p1_el;
  shift_t p2_az, p2_el;
  tail_t  p1_tail_next;
  oper_t  p1_az_next, p1_el_next;

  // Round roots, pre-rotate negative dx by a half turn
  always_comb begin
    meta_t m;
    logic [ROOT_W-1:0] h;
    logic signed [OPW-1:0] ax, ay, ez;
    m   = sq_pipe[ROOT_W].meta;
    h   = round_root(sq_pipe[ROOT_W].hor);
    ax  = {m.dx[DIFF_W-1], m.dx};
    ay  = {m.dy[DIFF_W-1], m.dy};
    ez  = {m.dz[DIFF_W-1], m.dz};
    p1_tail_next.status = m.status;
    p1_tail_next.blank  = m.blank;
    p1_tail_next.rng    = round_root(sq_pipe[ROOT_W].full);
    if (m.dx[DIFF_W-1]) p1_az_next = make_oper(-ax, -ay, 1'b1);
    else                p1_az_next = make_oper(ax, ay, 1'b0);
    p1_el_next = make_oper({1'b0, h}, ez, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= sq_valid[ROOT_W];
      p2_valid <= p1_valid;
    end
  end

  // Register the operands, then find the normalizing shift for each vector
  always_ff @(posedge clk) begin
    p1_tail <= p1_tail_next;
    p1_az   <= p1_az_next;
    p1_el   <= p1_el_next;
    p2_tail <= p1_tail;
    p2_az   <= make_shift(p1_az);
    p2_el   <= make_shift(p1_el);
  end

  // ---------------- CORDIC cell row ----------------
  logic    cr_valid [0:CORDIC_STEPS];
  cordic_t cr_pipe  [0:CORDIC_STEPS];

  // Apply the shift and seed the angle
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_valid[0] <= 1'b0;
    end else begin
      cr_valid[0] <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    cr_pipe[0].tail <= p2_tail;
    cr_pipe[0].az   <= make_vec(p2_az);
    cr_pipe[0].el   <= make_vec(p2_el);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    azr_cordic_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (cr_valid[i]),
      .up         (cr_pipe[i]),
      .down_valid (cr_valid[i+1]),
      .down       (cr_pipe[i+1])
    );
  end

  // ---------------- output stage ----------------
  res_t res_next;

  // Round angles, saturate elevation, blank on error or zero vector
  always_comb begin
    cordic_t c;
    logic signed [NW-1:0] az, el;
    c  = cr_pipe[CORDIC_STEPS];
    az = to_angle(c.az);
    el = to_angle(c.el);
    if (el > EL_LIM) el = EL_LIM;
    if (el < -EL_LIM) el = -EL_LIM;
    res_next.status = c.tail.status;
    if (c.tail.blank) begin
      res_next.azimuth   = '0;
      res_next.elevation = '0;
      res_next.range     = '0;
    end else begin
      res_next.azimuth   = az[ANGLE_W-1:0];
      res_next.elevation = el[ANGLE_W-1:0];
      res_next.range     = c.tail.rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // ---------------- checks ----------------
  `AZR_ASSERT_NXT(a_accept_enters, start && !busy, s0_valid)
  `AZR_ASSERT_IMP(a_error_blank, done && res.status != ST_OK,
                  res.azimuth == '0 && res.elevation == '0 && res.range == '0)
  `AZR_ASSERT_IMP(a_elev_bound, done,
                  $signed(res.elevation) <= $signed(EL_LIM[ANGLE_W-1:0]) &&
                  $signed(res.elevation) >= -$signed(EL_LIM[ANGLE_W-1:0]))
  `AZR_ASSERT_NXT(a_done_follows, cr_valid[CORDIC_STEPS], done)

endmodule
